// ----- rtl/usd_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream decoder.
package usd_pkg;

   // Lead byte thresholds
   localparam logic [7:0] LEAD_2 = 8'hC0;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] LEAD_5 = 8'hF8;
   localparam logic [7:0] LEAD_6 = 8'hFC;

   // Payload masks
   localparam logic [7:0] MASK_CONT = 8'h3F;
   localparam logic [7:0] MASK_2    = 8'h1F;
   localparam logic [7:0] MASK_3    = 8'h0F;
   localparam logic [7:0] MASK_4    = 8'h07;
   localparam logic [7:0] MASK_5    = 8'h03;
   localparam logic [7:0] MASK_6    = 8'h01;

   // Queue depths
   localparam int MID_DEPTH_DEF = 4;
   localparam int OUT_DEPTH_DEF = 4;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_MAX_CODE_POINTS = 1'b0;   // word index 0
   localparam logic [15:0] MAX_CP_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_SINGLE,
      OP_LEAD,
      OP_CONT
   } op_type;

   // Classified byte, front to back
   typedef struct packed {
      op_type     op;
      logic [7:0] bits;     // payload bits of this byte
      logic [2:0] len;      // announced length (lead only)
      logic [2:0] rem;      // continuation bytes still expected after this byte
      logic       eob;
   } mid_item_type;

   // Result item
   typedef struct packed {
      logic [30:0] code_point;
      logic [2:0]  seq_length;
      logic        truncated;
      logic [15:0] count_so_far;
      logic        buffer_done;
   } out_item_type;

   // Pad a cut-short sequence with zero payload for each missing byte
   function automatic logic [30:0] pad_missing(input logic [30:0] value,
                                               input logic [2:0] rem);
      logic [30:0] res;
      unique case (rem)
         3'd0:    res = value;
         3'd1:    res = value << 6;
         3'd2:    res = value << 12;
         3'd3:    res = value << 18;
         3'd4:    res = value << 24;
         3'd5:    res = value << 30;
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

// ----- rtl/usd_fifo.sv -----
// Small register queue used between the decoder stages and at the result side.
module usd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- rtl/usd_front.sv -----
// Front stage: accepts bytes, tracks sequence position and classifies each byte.
module usd_front import usd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   in_byte,
   input  logic         end_of_buffer,
   output mid_item_type item
);

   logic [2:0] rem_ff, rem_in;
   logic [2:0] lead_len;
   logic [7:0] lead_bits;
   logic [2:0] rem_next;

   // Lead byte decode
   always_comb begin
      priority if (in_byte < LEAD_2) begin
         lead_len  = 3'd1;
         lead_bits = in_byte;
      end else if (in_byte < LEAD_3) begin
         lead_len  = 3'd2;
         lead_bits = in_byte & MASK_2;
      end else if (in_byte < LEAD_4) begin
         lead_len  = 3'd3;
         lead_bits = in_byte & MASK_3;
      end else if (in_byte < LEAD_5) begin
         lead_len  = 3'd4;
         lead_bits = in_byte & MASK_4;
      end else if (in_byte < LEAD_6) begin
         lead_len  = 3'd5;
         lead_bits = in_byte & MASK_5;
      end else begin
         lead_len  = 3'd6;
         lead_bits = in_byte & MASK_6;
      end
   end

   // Classify against sequence position
   always_comb begin
      if (rem_ff == '0) begin
         rem_next  = lead_len - 3'd1;
         item.op   = (lead_len == 3'd1) ? OP_SINGLE : OP_LEAD;
         item.bits = lead_bits;
      end else begin
         rem_next  = rem_ff - 3'd1;
         item.op   = OP_CONT;
         item.bits = in_byte & MASK_CONT;
      end
      item.len = lead_len;
      item.rem = rem_next;
      item.eob = end_of_buffer;
      rem_in   = rem_ff;
      if (accept) begin
         rem_in = end_of_buffer ? 3'd0 : rem_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= 3'd5)
      else $error("front: continuation count out of range");

   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_buffer |=> rem_ff == 3'd0)
      else $error("front: sequence position not cleared at end of buffer");

endmodule

// ----- rtl/usd_back.sv -----
// Back stage: accumulates payload, applies the per-buffer limit, builds results.
module usd_back import usd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         valid,
   input  mid_item_type item,
   input  logic [15:0]  max_cp,
   output logic         out_push,
   output out_item_type out_item
);

   logic [30:0] acc_ff, acc_in;
   logic [2:0]  cur_len_ff, cur_len_in;
   logic [15:0] count_ff, count_in;
   logic [30:0] acc_shift;
   logic        emit_req;
   logic        under_limit;

   assign acc_shift   = {acc_ff[24:0], item.bits[5:0]};
   assign under_limit = (count_ff < max_cp);

   // Accumulate and form result
   always_comb begin
      acc_in                = acc_ff;
      cur_len_in            = cur_len_ff;
      count_in              = count_ff;
      emit_req              = 1'b0;
      out_item.code_point   = '0;
      out_item.seq_length   = cur_len_ff;
      out_item.truncated    = 1'b0;
      out_item.buffer_done  = item.eob;
      out_item.count_so_far = count_ff + 16'd1;
      unique case (item.op)
         OP_SINGLE: begin
            emit_req            = 1'b1;
            out_item.code_point = 31'(item.bits);
            out_item.seq_length = 3'd1;
         end
         OP_LEAD: begin
            acc_in     = 31'(item.bits);
            cur_len_in = item.len;
            // lead as last byte: always cut short
            emit_req            = item.eob;
            out_item.code_point = pad_missing(31'(item.bits), item.rem);
            out_item.seq_length = item.len;
            out_item.truncated  = 1'b1;
         end
         OP_CONT: begin
            if (item.rem == '0) begin
               emit_req            = 1'b1;
               out_item.code_point = acc_shift;
               acc_in              = '0;
               cur_len_in          = '0;
            end else begin
               acc_in              = acc_shift;
               emit_req            = item.eob;
               out_item.code_point = pad_missing(acc_shift, item.rem);
               out_item.truncated  = 1'b1;
            end
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
      out_push = valid && emit_req && under_limit;
      if (out_push) begin
         count_in = count_ff + 16'd1;
      end
      // buffer end returns everything to idle
      if (item.eob) begin
         acc_in     = '0;
         cur_len_in = '0;
         count_in   = '0;
      end
      if (!valid) begin
         acc_in     = acc_ff;
         cur_len_in = cur_len_ff;
         count_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         cur_len_ff <= '0;
         count_ff   <= '0;
      end else begin
         acc_ff     <= acc_in;
         cur_len_ff <= cur_len_in;
         count_ff   <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      out_push |-> out_item.count_so_far != 16'd0 && out_item.count_so_far <= max_cp)
      else $error("back: result count outside limit");

   a_trunc_len: assert property (@(posedge clock) disable iff (reset)
      out_push && out_item.truncated |->
         out_item.seq_length >= 3'd2 && out_item.seq_length <= 3'd6)
      else $error("back: truncated result with bad length");

endmodule

// ----- rtl/utf8_stream_decoder.sv -----
// Top level of the byte-serial six-byte UTF-8 decoder.
//
//   channel   ports              transfer when
//   request   req_*, push/full   push & !full
//   response  rsp_*, pop/empty   pop & !empty
//   csr       APB p*             psel & penable & pwrite (pready tied high)
//
// One byte per cycle sustained while the result queue has room; a byte's result
// passes the middle queue, then the back stage's accumulate step, into the result
// queue, from which it can then transfer out.
// Byte rate is set by the single accumulate-and-count step in the back stage.
// Reset is synchronous and clears sequence state, counts and both queues.
// A stalled result side fills the result queue, then the middle queue, then
// raises full; bytes that produce no result still need a free result slot.
module utf8_stream_decoder import usd_pkg::*; #(
   parameter int MID_DEPTH = MID_DEPTH_DEF,
   parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  push,
   output logic                  full,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_end_of_buffer,
   // response channel
   input  logic                  pop,
   output logic                  empty,
   output logic [30:0]           rsp_code_point,
   output logic [2:0]            rsp_seq_length,
   output logic                  rsp_truncated,
   output logic [15:0]           rsp_count_so_far,
   output logic                  rsp_buffer_done,
   // register port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic         req_accept;
   mid_item_type front_item;
   mid_item_type mid_item;
   logic         mid_full, mid_empty;
   logic         back_go;
   logic         out_push, out_full;
   out_item_type back_item;
   out_item_type rsp_item;
   logic [15:0]  max_cp_ff, max_cp_in;
   logic         csr_write;

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_MAX_CODE_POINTS) ?
                      CSR_DATA_W'(max_cp_ff) : '0;

   always_comb begin
      max_cp_in = max_cp_ff;
      if (csr_write && paddr[2] == REG_MAX_CODE_POINTS) begin
         max_cp_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cp_ff <= MAX_CP_RESET;
      end else begin
         max_cp_ff <= max_cp_in;
      end
   end

   // Front: classify incoming bytes
   assign full       = mid_full;
   assign req_accept = push && !mid_full;

   usd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .in_byte       (req_in_byte),
      .end_of_buffer (req_end_of_buffer),
      .item          (front_item)
   );

   // Queue between front and back
   usd_fifo #(
      .WIDTH ($bits(mid_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_item),
      .full  (mid_full),
      .pop   (back_go),
      .dout  (mid_item),
      .empty (mid_empty)
   );

   // Back: runs whenever an item waits and a result slot is free
   assign back_go = !mid_empty && !out_full;

   usd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .valid    (back_go),
      .item     (mid_item),
      .max_cp   (max_cp_ff),
      .out_push (out_push),
      .out_item (back_item)
   );

   // Result queue
   usd_fifo #(
      .WIDTH ($bits(out_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (back_item),
      .full  (out_full),
      .pop   (pop),
      .dout  (rsp_item),
      .empty (empty)
   );

   assign rsp_code_point   = rsp_item.code_point;
   assign rsp_seq_length   = rsp_item.seq_length;
   assign rsp_truncated    = rsp_item.truncated;
   assign rsp_count_so_far = rsp_item.count_so_far;
   assign rsp_buffer_done  = rsp_item.buffer_done;

endmodule
